// ----- sv/bsm_pkg.sv -----
`default_nettype none
package bsm_pkg;

  localparam logic [2:0] FN_CPU_READ  = 3'd0;
  localparam logic [2:0] FN_CPU_WRITE = 3'd1;
  localparam logic [2:0] FN_PPU_READ  = 3'd2;
  localparam logic [2:0] FN_TICK      = 3'd3;
  localparam logic [2:0] FN_ACK       = 3'd4;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_PRG  = 2'd1;
  localparam logic [1:0] TGT_CHR  = 2'd2;
  localparam logic [1:0] TGT_RAM  = 2'd3;

  // 8 KiB windows selected by bus_address[15:13]
  localparam logic [2:0] WIN_PATTERN  = 3'b000;
  localparam logic [2:0] WIN_RAM      = 3'b011;
  localparam logic [2:0] WIN_BANK_SEL = 3'b100;
  localparam logic [2:0] WIN_IRQ_LOAD = 3'b110;
  localparam logic [2:0] WIN_IRQ_EN   = 3'b111;

  // bank register indexes
  localparam logic [2:0] REG_CHR2K_A = 3'd0;
  localparam logic [2:0] REG_CHR2K_B = 3'd1;
  localparam logic [2:0] REG_PRG_A   = 3'd6;
  localparam logic [2:0] REG_PRG_B   = 3'd7;

  localparam logic [7:0] MASK_PRG_BANK = 8'h3f;
  localparam logic [7:0] MASK_CHR_2K   = 8'hfe;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [7:0][7:0] bank;
    logic            prg_mode;
    logic            chr_mode;
    logic [6:0]      prg_bank_count;
  } map_state_t;

endpackage
`default_nettype wire

// ----- sv/bank_switch_mapper_scanline_irq_unit.sv -----
// Bank mapper with scanline interrupt counter.
// Input channel: in_valid / in_stall carries one item (func, bus_address,
// write_data): cpu read, cpu write, ppu read, scanline tick or irq acknowledge.
// Output channel: out_valid / out_stall returns exactly one item per input:
// target memory, mem_address within it, and irq_active after the item.
// An item is taken at an edge where valid is high and stall is low.
// An accepted item goes through the input register, then mapping and state update
// into the result register, from which it is shown on the output.
// Throughput: one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; one more item can sit
// in the input register, after which in_stall rises until out_stall drops.
// cfg_write / cfg_data load the program bank count at any edge, no wait.
// Reset (rst, synchronous) clears bank registers, modes, the IRQ counter,
// reload, enable and flag, empties both stages and sets the bank count to 2.
`default_nettype none
module bank_switch_mapper_scanline_irq_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [15:0] bus_address,
  input  wire logic [7:0]  write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       target,
  output logic [18:0]      mem_address,
  output logic             irq_active
);
  import bsm_pkg::*;

  item_t      in_item, s1_item;
  map_state_t state;
  logic       s1_valid, s1_fire, out_ready, irq_flag_next;
  logic [1:0] map_target;
  logic [18:0] map_address;

  assign in_item.func        = func;
  assign in_item.bus_address = bus_address;
  assign in_item.write_data  = write_data;

  assign out_ready = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_ready;

  bsm_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (s1_fire),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  bsm_state u_state (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .fire          (s1_fire),
    .item          (s1_item),
    .state         (state),
    .irq_flag_next (irq_flag_next)
  );

  bsm_map u_map (
    .item        (s1_item),
    .state       (state),
    .target      (map_target),
    .mem_address (map_address)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      target      <= map_target;
      mem_address <= map_address;
      irq_active  <= irq_flag_next;
    end
  end

  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall with empty input stage");

  a_none_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && target == TGT_NONE) |-> mem_address == 19'd0)
    else $error("nonzero address with no target");

  a_chr_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && target == TGT_CHR) |-> !mem_address[18])
    else $error("character address out of range");

  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.func == FN_ACK) |=> (out_valid && !irq_active))
    else $error("acknowledge did not clear irq");

endmodule
`default_nettype wire

// ----- sv/bsm_in_stage.sv -----
`default_nettype none
module bsm_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bsm_pkg::item_t in_item,
  input  wire logic          advance,
  output logic               s1_valid,
  output bsm_pkg::item_t     s1_item
);
  import bsm_pkg::*;

  logic accept;

  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- sv/bsm_state.sv -----
`default_nettype none
module bsm_state (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_write,
  input  wire logic [6:0]     cfg_data,
  input  wire logic           fire,
  input  wire bsm_pkg::item_t item,
  output bsm_pkg::map_state_t state,
  output logic                irq_flag_next
);
  import bsm_pkg::*;

  logic [7:0][7:0] bank_regs;
  logic [2:0]      reg_select, reg_select_next;
  logic            prg_mode, prg_mode_next;
  logic            chr_mode, chr_mode_next;
  logic [7:0]      irq_count, irq_count_next;
  logic [7:0]      irq_reload, irq_reload_next;
  logic            irq_enable, irq_enable_next;
  logic            irq_flag;
  logic [6:0]      prg_bank_count;
  logic            bank_we;
  logic [7:0]      bank_wdata;
  logic [7:0]      count_tick;

  assign count_tick = (irq_count == 8'd0) ? irq_reload : irq_count - 8'd1;

  always_comb begin
    case (reg_select)
      REG_PRG_A, REG_PRG_B:     bank_wdata = item.write_data & MASK_PRG_BANK;
      REG_CHR2K_A, REG_CHR2K_B: bank_wdata = item.write_data & MASK_CHR_2K;
      default:                  bank_wdata = item.write_data;
    endcase
  end

  always_comb begin
    reg_select_next = reg_select;
    prg_mode_next   = prg_mode;
    chr_mode_next   = chr_mode;
    irq_count_next  = irq_count;
    irq_reload_next = irq_reload;
    irq_enable_next = irq_enable;
    irq_flag_next   = irq_flag;
    bank_we         = 1'b0;
    if (fire) begin
      case (item.func)
        FN_CPU_WRITE: begin
          case (item.bus_address[15:13])
            WIN_BANK_SEL: begin
              if (!item.bus_address[0]) begin
                reg_select_next = item.write_data[2:0];
                prg_mode_next   = item.write_data[6];
                chr_mode_next   = item.write_data[7];
              end else begin
                bank_we = 1'b1;
              end
            end
            WIN_IRQ_LOAD: begin
              if (!item.bus_address[0]) begin
                irq_reload_next = item.write_data;
              end else begin
                irq_count_next = 8'd0;
              end
            end
            WIN_IRQ_EN: begin
              if (!item.bus_address[0]) begin
                irq_enable_next = 1'b0;
                irq_flag_next   = 1'b0;
              end else begin
                irq_enable_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
        FN_TICK: begin
          irq_count_next = count_tick;
          if (count_tick == 8'd0 && irq_enable) begin
            irq_flag_next = 1'b1;
          end
        end
        FN_ACK: irq_flag_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_regs  <= '0;
      reg_select <= 3'd0;
      prg_mode   <= 1'b0;
      chr_mode   <= 1'b0;
      irq_count  <= 8'd0;
      irq_reload <= 8'd0;
      irq_enable <= 1'b0;
      irq_flag   <= 1'b0;
    end else begin
      if (bank_we) begin
        bank_regs[reg_select] <= bank_wdata;
      end
      reg_select <= reg_select_next;
      prg_mode   <= prg_mode_next;
      chr_mode   <= chr_mode_next;
      irq_count  <= irq_count_next;
      irq_reload <= irq_reload_next;
      irq_enable <= irq_enable_next;
      irq_flag   <= irq_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= 7'd2;
    end else if (cfg_write) begin
      prg_bank_count <= cfg_data;
    end
  end

  assign state.bank           = bank_regs;
  assign state.prg_mode       = prg_mode;
  assign state.chr_mode       = chr_mode;
  assign state.prg_bank_count = prg_bank_count;

endmodule
`default_nettype wire

// ----- sv/bsm_map.sv -----
`default_nettype none
module bsm_map (
  input  wire bsm_pkg::item_t      item,
  input  wire bsm_pkg::map_state_t state,
  output logic [1:0]               target,
  output logic [18:0]              mem_address
);
  import bsm_pkg::*;

  logic [6:0] last_full, second_full;
  logic [5:0] prg_bank;
  logic [2:0] slot;
  logic [7:0] chr_bank;
  logic [1:0] win;

  assign last_full   = state.prg_bank_count - 7'd1;
  assign second_full = state.prg_bank_count - 7'd2;
  assign win         = item.bus_address[14:13];
  assign slot        = item.bus_address[12:10] ^ {state.chr_mode, 2'b00};

  always_comb begin
    case (win)
      2'd1:    prg_bank = state.bank[REG_PRG_B][5:0];
      2'd3:    prg_bank = last_full[5:0];
      default: begin
        if ((win == 2'd0) == !state.prg_mode) begin
          prg_bank = state.bank[REG_PRG_A][5:0];
        end else begin
          prg_bank = second_full[5:0];
        end
      end
    endcase
  end

  always_comb begin
    if (!slot[2]) begin
      chr_bank = state.bank[{2'b00, slot[1]}] + {7'd0, slot[0]};
    end else begin
      chr_bank = state.bank[slot - 3'd2];
    end
  end

  always_comb begin
    target      = TGT_NONE;
    mem_address = 19'd0;
    case (item.func)
      FN_CPU_READ: begin
        if (item.bus_address[15:13] == WIN_RAM) begin
          target      = TGT_RAM;
          mem_address = {6'd0, item.bus_address[12:0]};
        end else if (item.bus_address[15]) begin
          target      = TGT_PRG;
          mem_address = {prg_bank, item.bus_address[12:0]};
        end
      end
      FN_PPU_READ: begin
        if (item.bus_address[15:13] == WIN_PATTERN) begin
          target      = TGT_CHR;
          mem_address = {1'b0, chr_bank, item.bus_address[9:0]};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
